>>> hdl/mbrs_pkg.sv
package mbrs_pkg;

    localparam int REG_DEPTH_DEF = 64;
    localparam int MAX_READ_DEF  = 29;

    localparam logic [7:0] FC_READ_HOLD  = 8'd3;
    localparam logic [7:0] FC_READ_INPUT = 8'd4;
    localparam logic [7:0] FC_WRITE_ONE  = 8'd6;
    localparam logic [7:0] FC_WRITE_MANY = 8'd16;

    localparam logic [2:0] CFG_STATION   = 3'd0;
    localparam logic [2:0] CFG_IN_BASE   = 3'd1;
    localparam logic [2:0] CFG_IN_COUNT  = 3'd2;
    localparam logic [2:0] CFG_HO_BASE   = 3'd3;
    localparam logic [2:0] CFG_HO_COUNT  = 3'd4;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_ECHO  = 2'd2;

    // classified job handed from front to back
    typedef struct packed {
        logic [1:0]  op;
        logic        hold;      // read from holding store
        logic        notice;    // emit update notice first
        logic        echo;      // emit echo frame
        logic [7:0]  code;
        logic [15:0] addr;
        logic [15:0] cnt;
        logic [15:0] idx;       // store index (write target or read start)
        logic        wr_en;     // store write needed
        logic [15:0] wdata;
    } t_job;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {8'd0, b};
        for (int k = 0; k < 8; k++) begin
            x = x[0] ? ((x >> 1) ^ 16'hA001) : (x >> 1);
        end
        return x;
    endfunction

endpackage

>>> hdl/mbrs_ram.sv
module mbrs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> hdl/mbrs_front.sv
module mbrs_front #(
    parameter int REG_DEPTH = mbrs_pkg::REG_DEPTH_DEF,
    parameter int MAX_READ  = mbrs_pkg::MAX_READ_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_func,
    input  logic [7:0]         i_station,
    input  logic [7:0]         i_code,
    input  logic [15:0]        i_start_addr,
    input  logic [15:0]        i_count_or_value,
    input  logic [15:0]        i_data_word,
    input  logic               i_word_last,
    input  logic [7:0]         i_station_id,
    input  logic [15:0]        i_input_base,
    input  logic [6:0]         i_input_count,
    input  logic [15:0]        i_holding_base,
    input  logic [6:0]         i_holding_count,
    output logic               o_job_valid,
    output mbrs_pkg::t_job     o_job,
    input  logic               i_job_full,
    output logic               o_load_we,
    output logic [15:0]        o_load_idx,
    output logic [15:0]        o_load_data
);
    logic [6:0]  r_run_index;
    logic [6:0]  n_run_index;
    logic        acc;
    logic        bcast, taken;
    logic [15:0] in_eff, ho_eff;
    logic [17:0] in_lim, ho_lim;
    logic        in_ok1, ho_ok1, ho_okn, in_okn;
    logic [15:0] in_idx, ho_idx;
    logic [15:0] ho_j;
    logic        rd_ok;
    logic        is_rd;

    assign o_stall = i_job_full;
    assign acc     = i_valid && !i_job_full;
    assign bcast   = (i_station == 8'd0);
    assign taken   = bcast || (i_station == i_station_id);

    always_comb begin
        in_eff = ({9'd0, i_input_count} > 16'(REG_DEPTH)) ? 16'(REG_DEPTH)
               : {9'd0, i_input_count};
        ho_eff = ({9'd0, i_holding_count} > 16'(REG_DEPTH)) ? 16'(REG_DEPTH)
               : {9'd0, i_holding_count};
        in_lim = {2'b0, i_input_base} + {2'b0, in_eff};
        ho_lim = {2'b0, i_holding_base} + {2'b0, ho_eff};
        in_idx = i_start_addr - i_input_base;
        ho_idx = i_start_addr - i_holding_base;
        in_ok1 = (in_eff != 0) && (i_start_addr >= i_input_base)
               && ({2'b0, i_start_addr} + 18'd1 <= in_lim);
        ho_ok1 = (ho_eff != 0) && (i_start_addr >= i_holding_base)
               && ({2'b0, i_start_addr} + 18'd1 <= ho_lim);
        in_okn = (in_eff != 0) && (i_start_addr >= i_input_base)
               && ({2'b0, i_start_addr} + {2'b0, i_count_or_value} <= in_lim);
        ho_okn = (ho_eff != 0) && (i_start_addr >= i_holding_base)
               && ({2'b0, i_start_addr} + {2'b0, i_count_or_value} <= ho_lim);
        ho_j   = ho_idx + {9'd0, r_run_index};
        is_rd  = (i_code == mbrs_pkg::FC_READ_HOLD) || (i_code == mbrs_pkg::FC_READ_INPUT);
        rd_ok  = !bcast && (i_count_or_value <= 16'(MAX_READ))
               && ((i_code == mbrs_pkg::FC_READ_HOLD) ? ho_okn : in_okn);
    end

    always_comb begin
        o_job       = '0;
        o_job_valid = 1'b0;
        n_run_index = r_run_index;
        o_load_we   = 1'b0;
        o_load_idx  = in_idx;
        o_load_data = i_data_word;
        o_job.code  = i_code;
        o_job.addr  = i_start_addr;
        o_job.cnt   = i_count_or_value;
        if (acc) begin
            if (i_func) begin
                n_run_index = '0;
                o_load_we   = in_ok1 && (in_idx < 16'(REG_DEPTH));
            end else begin
                if (!taken || i_code != mbrs_pkg::FC_WRITE_MANY) begin
                    n_run_index = '0;
                end
                if (taken && is_rd) begin
                    o_job_valid = rd_ok;
                    o_job.op    = mbrs_pkg::OP_READ;
                    o_job.hold  = (i_code == mbrs_pkg::FC_READ_HOLD);
                    o_job.idx   = (i_code == mbrs_pkg::FC_READ_HOLD) ? ho_idx : in_idx;
                    o_job.echo  = 1'b1;
                end else if (taken && i_code == mbrs_pkg::FC_WRITE_ONE) begin
                    o_job_valid  = ho_ok1;
                    o_job.op     = mbrs_pkg::OP_WRITE;
                    o_job.notice = 1'b1;
                    o_job.echo   = !bcast;
                    o_job.cnt    = 16'd1;
                    o_job.wdata  = i_count_or_value;
                    o_job.idx    = ho_idx;
                    o_job.wr_en  = ho_idx < 16'(REG_DEPTH);
                    o_job.addr   = i_start_addr;
                end else if (taken && i_code == mbrs_pkg::FC_WRITE_MANY) begin
                    o_job.op     = mbrs_pkg::OP_WRITE;
                    o_job.wdata  = i_data_word;
                    o_job.idx    = ho_j;
                    o_job.wr_en  = ho_okn && ({9'd0, r_run_index} < i_count_or_value)
                                 && (ho_j < 16'(REG_DEPTH));
                    o_job.notice = i_word_last && ho_okn;
                    o_job.echo   = i_word_last && ho_okn && !bcast;
                    o_job_valid  = o_job.wr_en || o_job.notice;
                    if (i_word_last) begin
                        n_run_index = '0;
                    end else if (r_run_index != 7'd127) begin
                        n_run_index = r_run_index + 7'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_index <= '0;
        end else begin
            r_run_index <= n_run_index;
        end
    end
endmodule

>>> hdl/mbrs_back.sv
module mbrs_back #(
    parameter int REG_DEPTH = mbrs_pkg::REG_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_job_valid,
    input  mbrs_pkg::t_job               i_job,
    output logic                         o_job_pop,
    output logic                         o_idle,
    input  logic [7:0]                   i_station_id,
    output logic                         o_hwe,
    output logic [$clog2(REG_DEPTH)-1:0] o_hwaddr,
    output logic [15:0]                  o_hwdata,
    output logic [$clog2(REG_DEPTH)-1:0] o_raddr,
    output logic                         o_rsel_hold,
    input  logic [15:0]                  i_in_rdata,
    input  logic [15:0]                  i_ho_rdata,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_out_kind,
    output logic [7:0]                   o_out_byte,
    output logic [15:0]                  o_notice_addr,
    output logic [15:0]                  o_notice_count,
    output logic                         o_out_last
);
    localparam int AW = $clog2(REG_DEPTH);
    localparam logic [2:0] S_IDLE = 3'd0, S_NOTE = 3'd1, S_HEAD = 3'd2,
                           S_RD = 3'd3, S_WORD = 3'd4, S_CRC = 3'd5;

    logic [2:0]  r_state, n_state;
    mbrs_pkg::t_job r_job, n_job;
    logic [2:0]  r_hcnt, n_hcnt;
    logic [5:0]  r_wcnt, n_wcnt;
    logic        r_lo, n_lo;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_word, n_word;
    logic        r_wait, n_wait;
    logic        r_valid, n_valid;
    logic        r_kind, n_kind;
    logic [7:0]  r_byte, n_byte;
    logic [15:0] r_naddr, n_naddr, r_ncnt, n_ncnt;
    logic        r_last, n_last;
    logic        slot_free;
    logic [7:0]  hbyte;
    logic [15:0] ridx;
    logic [15:0] echo_val;

    assign slot_free = !r_valid || !i_stall;
    assign ridx      = r_job.idx + {10'd0, r_wcnt};
    assign o_raddr   = ridx[AW-1:0];
    assign o_rsel_hold = r_job.hold;
    assign o_idle    = (r_state == S_IDLE);
    // single write echoes the value, multi-word write echoes the count
    assign echo_val  = (r_job.code == mbrs_pkg::FC_WRITE_ONE) ? r_job.wdata : r_job.cnt;

    always_comb begin
        case (r_hcnt)
            3'd0: hbyte = i_station_id;
            3'd1: hbyte = r_job.code;
            3'd2: hbyte = (r_job.op == mbrs_pkg::OP_READ) ? {r_job.cnt[6:0], 1'b0}
                                                          : r_job.addr[15:8];
            3'd3: hbyte = r_job.addr[7:0];
            3'd4: hbyte = echo_val[15:8];
            3'd5: hbyte = echo_val[7:0];
            default: hbyte = 8'd0;
        endcase
    end

    always_comb begin
        n_state = r_state; n_job = r_job; n_hcnt = r_hcnt; n_wcnt = r_wcnt;
        n_lo = r_lo; n_crc = r_crc; n_word = r_word; n_wait = r_wait;
        n_valid = r_valid && i_stall;
        n_kind = r_kind; n_byte = r_byte; n_naddr = r_naddr; n_ncnt = r_ncnt;
        n_last = r_last;
        o_job_pop = 1'b0;
        o_hwe = 1'b0;
        o_hwaddr = r_job.idx[AW-1:0];
        o_hwdata = r_job.wdata;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_job = i_job;
                    n_hcnt = '0; n_wcnt = '0; n_lo = 1'b0; n_crc = 16'hFFFF;
                    o_hwe = i_job.wr_en;
                    o_hwaddr = i_job.idx[AW-1:0];
                    o_hwdata = i_job.wdata;
                    if (i_job.notice) n_state = S_NOTE;
                    else if (i_job.echo) n_state = S_HEAD;
                end
            end
            S_NOTE: if (slot_free) begin
                n_valid = 1'b1; n_kind = 1'b1; n_byte = '0;
                n_naddr = r_job.addr; n_ncnt = r_job.cnt; n_last = !r_job.echo;
                n_state = r_job.echo ? S_HEAD : S_IDLE;
            end
            S_HEAD: if (slot_free) begin
                n_valid = 1'b1; n_kind = 1'b0; n_byte = hbyte;
                n_naddr = '0; n_ncnt = '0; n_last = 1'b0;
                n_crc = mbrs_pkg::crc_byte(r_crc, hbyte);
                n_hcnt = r_hcnt + 3'd1;
                if (r_job.op == mbrs_pkg::OP_READ) begin
                    if (r_hcnt == 3'd2) n_state = (r_job.cnt == 16'd0) ? S_CRC : S_RD;
                end else if (r_hcnt == 3'd5) begin
                    n_state = S_CRC;
                end
                n_wait = 1'b0;
            end
            S_RD: begin
                // read address settles here, data registered next cycle
                if (r_wait) begin
                    n_word = r_job.hold ? i_ho_rdata : i_in_rdata;
                    if (ridx >= 16'(REG_DEPTH)) n_word = '0;
                    n_state = S_WORD; n_lo = 1'b0;
                end
                n_wait = !r_wait;
            end
            S_WORD: if (slot_free) begin
                n_valid = 1'b1; n_kind = 1'b0; n_last = 1'b0;
                n_naddr = '0; n_ncnt = '0;
                n_byte = r_lo ? r_word[7:0] : r_word[15:8];
                n_crc = mbrs_pkg::crc_byte(r_crc, n_byte);
                n_lo = !r_lo;
                if (r_lo) begin
                    n_wcnt = r_wcnt + 6'd1;
                    n_wait = 1'b0;
                    n_state = ({10'd0, r_wcnt} + 16'd1 == r_job.cnt) ? S_CRC : S_RD;
                end
            end
            S_CRC: if (slot_free) begin
                n_valid = 1'b1; n_kind = 1'b0; n_naddr = '0; n_ncnt = '0;
                n_byte = r_lo ? r_crc[15:8] : r_crc[7:0];
                n_last = r_lo;
                n_lo = !r_lo;
                if (r_lo) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_HEAD && slot_free && n_state == S_CRC) n_lo = 1'b0;
        if (r_state == S_WORD && slot_free && n_state == S_CRC) n_lo = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_wait  <= n_wait;
        end
        r_job <= n_job; r_hcnt <= n_hcnt; r_wcnt <= n_wcnt; r_lo <= n_lo;
        r_crc <= n_crc; r_word <= n_word; r_kind <= n_kind; r_byte <= n_byte;
        r_naddr <= n_naddr; r_ncnt <= n_ncnt; r_last <= n_last;
    end

    assign o_valid        = r_valid;
    assign o_out_kind     = r_kind;
    assign o_out_byte     = r_byte;
    assign o_notice_addr  = r_naddr;
    assign o_notice_count = r_ncnt;
    assign o_out_last     = r_last;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_stall |=> r_valid && $stable(r_byte))
        else $error("result changed under stall");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |-> r_state == S_IDLE)
        else $error("job popped while busy");
    a_notice_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_kind |-> r_byte == 8'd0)
        else $error("notice with byte");
endmodule

>>> hdl/modbus_rtu_slave_register_handler.sv
// Modbus RTU slave register handler.
// Input channel: one decoded request item per handshake (i_valid/o_stall).
// func 1 items load an input register locally and yield nothing.
// Output channel: response bytes (kind 0) and holding update notices
// (kind 1), o_valid/i_stall; o_out_last flags the final item of a run.
// A front stage classifies each item and window-checks it combinationally,
// performs local loads, and pushes a job into a two-entry queue; the back
// stage writes the holding store and streams the answer with CRC-16.
// A read answer of N words is 3 header bytes, then per word a registered
// RAM read and its two bytes, then 2 CRC bytes; a write answer is an
// update notice plus an 8-byte echo, the echo left out for broadcast.
// The back pops a new job only while idle, so silent write words go one
// per cycle while it stays idle.
// The front stalls while the queue is full, and holds a local load until
// the queue and the back are empty so no queued read sees a later load.
// Reset: synchronous, active low; config returns to station 1 and zero
// windows. Both register stores start at zero by a clearing pass over every
// store address after reset, during which no item is accepted.
// Receiver stall holds the current result and back-pressures the queue.
module modbus_rtu_slave_register_handler #(
    parameter int REG_DEPTH = mbrs_pkg::REG_DEPTH_DEF,
    parameter int MAX_READ  = mbrs_pkg::MAX_READ_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [7:0]  i_station,
    input  logic [7:0]  i_code,
    input  logic [15:0] i_start_addr,
    input  logic [15:0] i_count_or_value,
    input  logic [15:0] i_data_word,
    input  logic        i_word_last,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_out_kind,
    output logic [7:0]  o_out_byte,
    output logic [15:0] o_notice_addr,
    output logic [15:0] o_notice_count,
    output logic        o_out_last
);
    localparam int AW = $clog2(REG_DEPTH);

    // configuration
    logic [7:0]  r_station_id;
    logic [15:0] r_input_base, r_holding_base;
    logic [6:0]  r_input_count, r_holding_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station_id    <= 8'd1;
            r_input_base    <= '0;
            r_input_count   <= '0;
            r_holding_base  <= '0;
            r_holding_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mbrs_pkg::CFG_STATION:  r_station_id    <= i_cfg_data[7:0];
                mbrs_pkg::CFG_IN_BASE:  r_input_base    <= i_cfg_data;
                mbrs_pkg::CFG_IN_COUNT: r_input_count   <= i_cfg_data[6:0];
                mbrs_pkg::CFG_HO_BASE:  r_holding_base  <= i_cfg_data;
                mbrs_pkg::CFG_HO_COUNT: r_holding_count <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // clearing pass over both stores after reset
    logic [AW:0] r_clr;
    logic        clearing;
    assign clearing = !r_clr[AW];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr <= '0;
        else if (clearing) r_clr <= r_clr + 1'b1;
    end

    // front
    logic           f_valid, f_stall_q;
    mbrs_pkg::t_job f_job;
    logic           ld_we;
    logic [15:0]    ld_idx, ld_data;
    logic           front_stall;
    logic           q_full, q_pop;
    logic           b_idle;
    logic [1:0]     r_qcnt;
    logic           load_hold;

    // hold a local load while an earlier job could still read the input store
    assign load_hold = i_func && (r_qcnt != 2'd0 || !b_idle);
    assign f_valid   = i_valid && !clearing && !load_hold;
    assign o_stall   = front_stall || clearing || load_hold;

    mbrs_front #(.REG_DEPTH(REG_DEPTH), .MAX_READ(MAX_READ)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_stall(front_stall),
        .i_func, .i_station, .i_code, .i_start_addr, .i_count_or_value,
        .i_data_word, .i_word_last,
        .i_station_id(r_station_id), .i_input_base(r_input_base),
        .i_input_count(r_input_count), .i_holding_base(r_holding_base),
        .i_holding_count(r_holding_count),
        .o_job_valid(f_stall_q), .o_job(f_job), .i_job_full(q_full),
        .o_load_we(ld_we), .o_load_idx(ld_idx), .o_load_data(ld_data)
    );

    // two-entry job queue
    mbrs_pkg::t_job r_q [2];
    logic       r_qrd, r_qwr;
    assign q_full = (r_qcnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qcnt <= '0; r_qrd <= 1'b0; r_qwr <= 1'b0;
        end else begin
            if (f_stall_q) r_qwr <= !r_qwr;
            if (q_pop) r_qrd <= !r_qrd;
            r_qcnt <= r_qcnt + {1'b0, f_stall_q} - {1'b0, q_pop};
        end
        if (f_stall_q) r_q[r_qwr] <= f_job;
    end

    // stores
    logic                 b_hwe;
    logic [AW-1:0]        b_hwaddr, b_raddr;
    logic [15:0]          b_hwdata, in_rdata, ho_rdata;
    logic                 b_rsel;

    mbrs_ram #(.WIDTH(16), .DEPTH(REG_DEPTH)) u_in_ram (
        .i_clk,
        .i_we(clearing || ld_we),
        .i_waddr(clearing ? r_clr[AW-1:0] : ld_idx[AW-1:0]),
        .i_wdata(clearing ? 16'd0 : ld_data),
        .i_raddr(b_raddr), .o_rdata(in_rdata)
    );

    mbrs_ram #(.WIDTH(16), .DEPTH(REG_DEPTH)) u_ho_ram (
        .i_clk,
        .i_we(clearing || b_hwe),
        .i_waddr(clearing ? r_clr[AW-1:0] : b_hwaddr),
        .i_wdata(clearing ? 16'd0 : b_hwdata),
        .i_raddr(b_raddr), .o_rdata(ho_rdata)
    );

    mbrs_back #(.REG_DEPTH(REG_DEPTH)) u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(r_qcnt != 2'd0 && !clearing), .i_job(r_q[r_qrd]), .o_job_pop(q_pop),
        .o_idle(b_idle),
        .i_station_id(r_station_id),
        .o_hwe(b_hwe), .o_hwaddr(b_hwaddr), .o_hwdata(b_hwdata),
        .o_raddr(b_raddr), .o_rsel_hold(b_rsel),
        .i_in_rdata(in_rdata), .i_ho_rdata(ho_rdata),
        .o_valid, .i_stall, .o_out_kind, .o_out_byte, .o_notice_addr,
        .o_notice_count, .o_out_last
    );

    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcnt <= 2'd2) else $error("queue overflow");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !f_stall_q) else $error("push into full queue");
    a_clear_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> o_stall && !q_pop) else $error("work during clearing");
    a_sel_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> r_qcnt != 2'd0) else $error("pop empty queue");
    a_rsel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> b_rsel == b_rsel) else $error("select");
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld_we && !clearing |-> r_qcnt == 2'd0 && b_idle) else $error("load while busy");
endmodule

>>> dv/tb_modbus_rtu_slave_register_handler.sv
module tb_modbus_rtu_slave_register_handler;

    localparam int          DEPTH      = 64;
    localparam int          READ_MAX   = 29;
    localparam int          CYCLE_CAP  = 400000;
    localparam logic [7:0]  FC_UNKNOWN = 8'd7;

    typedef struct {
        bit        func;
        bit [7:0]  station;
        bit [7:0]  code;
        bit [15:0] start;
        bit [15:0] cv;
        bit [15:0] word;
        bit        last;
    } t_req;

    typedef struct {
        bit        kind;
        bit [7:0]  byte_v;
        bit [15:0] addr;
        bit [15:0] cnt;
        bit        last;
    } t_rsp;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic        i_func = 0;
    logic [7:0]  i_station = 0;
    logic [7:0]  i_code = 0;
    logic [15:0] i_start_addr = 0;
    logic [15:0] i_count_or_value = 0;
    logic [15:0] i_data_word = 0;
    logic        i_word_last = 0;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_index = 0;
    logic [15:0] i_cfg_data = 0;
    logic        o_valid;
    logic        i_stall = 0;
    logic        o_out_kind;
    logic [7:0]  o_out_byte;
    logic [15:0] o_notice_addr;
    logic [15:0] o_notice_count;
    logic        o_out_last;

    modbus_rtu_slave_register_handler dut (.*);

    always #6 i_clk = ~i_clk;

    // shadow of the block: stores, run position, CRC and config
    bit [15:0] in_mem [DEPTH];
    bit [15:0] ho_mem [DEPTH];
    bit [15:0] crc_run;
    int        run_pos;
    int        my_station = 1, in_base = 0, in_size = 0, ho_base = 0, ho_size = 0;

    t_req pend_q[$];
    t_rsp answer_q[$];
    t_req cur;
    int   snd_idle = 19, rcv_idle = 56, rcv_hold = 0;
    int   n_acc = 0, n_rsp = 0, n_notice = 0, errors = 0, cyc = 0;

    function automatic int eff_of(int c);
        return c > DEPTH ? DEPTH : c;
    endfunction

    function automatic bit win_ok(int base, int size, int start, int len, output int idx);
        int e;
        e = eff_of(size);
        idx = start - base;
        return !(e == 0 || start < base || start + len > base + e);
    endfunction

    task automatic push_rsp(bit kind, bit [7:0] b, bit [15:0] a, bit [15:0] c);
        t_rsp r;
        r.kind = kind; r.byte_v = b; r.addr = a; r.cnt = c; r.last = 0;
        answer_q.push_back(r);
    endtask

    task automatic emit_crc_byte(bit [7:0] b);
        crc_run ^= {8'd0, b};
        for (int k = 0; k < 8; k++)
            crc_run = crc_run[0] ? ((crc_run >> 1) ^ 16'hA001) : (crc_run >> 1);
        push_rsp(0, b, 0, 0);
    endtask

    task automatic emit_tail();
        bit [15:0] c;
        c = crc_run;
        push_rsp(0, c[7:0], 0, 0);
        push_rsp(0, c[15:8], 0, 0);
    endtask

    task automatic emit_echo(bit [7:0] code, bit [15:0] a, bit [15:0] v);
        crc_run = 16'hFFFF;
        emit_crc_byte(my_station[7:0]);
        emit_crc_byte(code);
        emit_crc_byte(a[15:8]);
        emit_crc_byte(a[7:0]);
        emit_crc_byte(v[15:8]);
        emit_crc_byte(v[7:0]);
        emit_tail();
    endtask

    // work out the answer run of one accepted item and update the shadow state
    task automatic apply_request(t_req it);
        int   idx, n0;
        bit   bc, taken, ok, hold;
        t_rsp r;
        bit [15:0] w;
        n0 = answer_q.size();
        if (it.func) begin
            run_pos = 0;
            if (win_ok(in_base, in_size, it.start, 1, idx)) in_mem[idx] = it.word;
        end else begin
            bc = (it.station == 0);
            taken = bc || it.station == my_station;
            if (!taken || it.code != mbrs_pkg::FC_WRITE_MANY) run_pos = 0;
            if (taken) begin
                if (it.code == mbrs_pkg::FC_READ_HOLD || it.code == mbrs_pkg::FC_READ_INPUT) begin
                    hold = (it.code == mbrs_pkg::FC_READ_HOLD);
                    ok = hold ? win_ok(ho_base, ho_size, it.start, it.cv, idx)
                              : win_ok(in_base, in_size, it.start, it.cv, idx);
                    if (!bc && it.cv <= READ_MAX && ok) begin
                        crc_run = 16'hFFFF;
                        emit_crc_byte(my_station[7:0]);
                        emit_crc_byte(it.code);
                        emit_crc_byte(8'(it.cv * 2));
                        for (int i = 0; i < it.cv; i++) begin
                            w = hold ? ho_mem[idx + i] : in_mem[idx + i];
                            emit_crc_byte(w[15:8]);
                            emit_crc_byte(w[7:0]);
                        end
                        emit_tail();
                    end
                end else if (it.code == mbrs_pkg::FC_WRITE_ONE) begin
                    if (win_ok(ho_base, ho_size, it.start, 1, idx)) begin
                        ho_mem[idx] = it.cv;
                        push_rsp(1, 0, it.start, 1);
                        n_notice++;
                        if (!bc) emit_echo(mbrs_pkg::FC_WRITE_ONE, it.start, it.cv);
                    end
                end else if (it.code == mbrs_pkg::FC_WRITE_MANY) begin
                    ok = win_ok(ho_base, ho_size, it.start, it.cv, idx);
                    if (ok && run_pos < it.cv) ho_mem[idx + run_pos] = it.word;
                    if (run_pos < 127) run_pos++;
                    if (it.last) begin
                        run_pos = 0;
                        if (ok) begin
                            push_rsp(1, 0, it.start, it.cv);
                            n_notice++;
                            if (!bc) emit_echo(mbrs_pkg::FC_WRITE_MANY, it.start, it.cv);
                        end
                    end
                end
            end
        end
        if (answer_q.size() > n0) begin
            r = answer_q.pop_back();
            r.last = 1;
            answer_q.push_back(r);
        end
    endtask

    // sender: hold a stalled item, otherwise offer the next one or idle
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                apply_request(cur);
                n_acc++;
            end
            if (!(i_valid && o_stall)) begin
                if (pend_q.size() > 0 && $urandom_range(99) >= snd_idle) begin
                    cur = pend_q.pop_front();
                    i_valid <= 1;
                    i_func <= cur.func;
                    i_station <= cur.station;
                    i_code <= cur.code;
                    i_start_addr <= cur.start;
                    i_count_or_value <= cur.cv;
                    i_data_word <= cur.word;
                    i_word_last <= cur.last;
                end else begin
                    i_valid <= 0;
                end
            end
        end
    end

    // receiver stall: long hold-off when asked, random otherwise
    always @(posedge i_clk) begin
        if (rcv_hold > 0) begin
            rcv_hold <= rcv_hold - 1;
            i_stall <= 1;
        end else begin
            i_stall <= ($urandom_range(99) < rcv_idle);
        end
    end

    // compare each accepted result with the oldest expected one
    always @(posedge i_clk) begin
        t_rsp e;
        if (i_rst_n && o_valid && !i_stall) begin
            n_rsp++;
            if (answer_q.size() == 0) begin
                $display("%0t: unexpected result kind=%0d byte=%h addr=%h cnt=%h last=%0d",
                         $time, o_out_kind, o_out_byte, o_notice_addr, o_notice_count,
                         o_out_last);
                errors++;
            end else begin
                e = answer_q.pop_front();
                if (o_out_kind !== e.kind || o_out_byte !== e.byte_v ||
                    o_notice_addr !== e.addr || o_notice_count !== e.cnt ||
                    o_out_last !== e.last) begin
                    $display("%0t: expected kind=%0d byte=%h addr=%h cnt=%h last=%0d",
                             $time, e.kind, e.byte_v, e.addr, e.cnt, e.last);
                    $display("%0t:   actual kind=%0d byte=%h addr=%h cnt=%h last=%0d",
                             $time, o_out_kind, o_out_byte, o_notice_addr, o_notice_count,
                             o_out_last);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_CAP) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic add(bit f, bit [7:0] st, bit [7:0] code, bit [15:0] sa, bit [15:0] cv,
                       bit [15:0] dw, bit lst);
        t_req r;
        r.func = f; r.station = st; r.code = code; r.start = sa; r.cv = cv;
        r.word = dw; r.last = lst;
        pend_q.push_back(r);
    endtask

    // write one register; only called with the block idle
    task automatic cfg_write(logic [2:0] idx, int val);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= 16'(val);
        case (idx)
            mbrs_pkg::CFG_STATION:  my_station = val & 8'hFF;
            mbrs_pkg::CFG_IN_BASE:  in_base = val & 16'hFFFF;
            mbrs_pkg::CFG_IN_COUNT: in_size = val & 7'h7F;
            mbrs_pkg::CFG_HO_BASE:  ho_base = val & 16'hFFFF;
            mbrs_pkg::CFG_HO_COUNT: ho_size = val & 7'h7F;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic set_windows(int st, int ib, int ic, int hb, int hc);
        cfg_write(mbrs_pkg::CFG_STATION, st);
        cfg_write(mbrs_pkg::CFG_IN_BASE, ib);
        cfg_write(mbrs_pkg::CFG_IN_COUNT, ic);
        cfg_write(mbrs_pkg::CFG_HO_BASE, hb);
        cfg_write(mbrs_pkg::CFG_HO_COUNT, hc);
    endtask

    // drain: all items taken, all answers seen, then let silent items settle
    task automatic drain();
        @(negedge i_clk);
        while (pend_q.size() > 0 || i_valid || answer_q.size() > 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    function automatic bit [7:0] req_station();
        return ($urandom_range(9) == 0) ? 8'd0 : 8'(my_station);
    endfunction

    // start address inside a window of size eff for a run of len words, random if the run cannot fit
    function automatic bit [15:0] pick_start(int base, int eff, int len);
        if (eff == 0 || len > eff) return 16'($urandom);
        return 16'(base + $urandom_range(0, eff - len));
    endfunction

    task automatic random_requests(int n);
        int k, e, len, nw;
        bit [15:0] sa;
        bit [7:0]  st;
        for (int t = 0; t < n; t++) begin
            k = $urandom_range(99);
            if (k < 35) begin
                // reads: mostly short, sometimes up to one word past the limit
                e = (k < 18) ? eff_of(ho_size) : eff_of(in_size);
                len = $urandom_range(0, (e < 8) ? e : 8);
                if ($urandom_range(7) == 0) len = $urandom_range(0, (e < 30) ? e : 30);
                sa = (k < 18) ? pick_start(ho_base, e, len) : pick_start(in_base, e, len);
                add(0, ($urandom_range(19) == 0) ? 8'd0 : 8'(my_station),
                    (k < 18) ? mbrs_pkg::FC_READ_HOLD : mbrs_pkg::FC_READ_INPUT, sa,
                    16'(len), 16'($urandom), 0);
            end else if (k < 50) begin
                add(0, req_station(), mbrs_pkg::FC_WRITE_ONE,
                    pick_start(ho_base, eff_of(ho_size), 1),
                    16'($urandom), 16'($urandom), 1'($urandom_range(1)));
            end else if (k < 68) begin
                // multi-word write run, word count sometimes off the header
                e = eff_of(ho_size);
                len = $urandom_range(0, (e < 8) ? e : 8);
                sa = pick_start(ho_base, e, len);
                st = req_station();
                nw = len + $urandom_range(0, 2) - $urandom_range(0, 1);
                if (nw < 1) nw = 1;
                for (int i = 0; i < nw; i++)
                    add(0, st, mbrs_pkg::FC_WRITE_MANY, sa, 16'(len), 16'($urandom),
                        i == nw - 1);
            end else if (k < 80) begin
                e = eff_of(in_size);
                sa = ($urandom_range(4) == 0) ? 16'($urandom) : pick_start(in_base, e, 1);
                add(1, 8'($urandom), 8'($urandom), sa, 16'($urandom), 16'($urandom),
                    1'($urandom_range(1)));
            end else begin
                add(1'($urandom_range(1)), 8'($urandom), 8'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        crc_run = 16'hFFFF;
        run_pos = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;

        // reset windows are off: everything is dropped
        random_requests(2);
        drain();

        // directed pass on small windows
        set_windows(5, 16'h0010, 8, 16'h0100, 10);
        add(1, 0, 0, 16'h0010, 0, 16'hFFFF, 0);
        add(1, 8'hFF, 8'hFF, 16'h0017, 0, 16'h1234, 1);
        add(1, 5, 0, 16'h0018, 0, 16'hDEAD, 0);
        add(1, 5, 0, 16'h000F, 0, 16'hBEEF, 0);
        add(0, 5, mbrs_pkg::FC_READ_INPUT, 16'h0010, 8, 0, 0);
        add(0, 5, mbrs_pkg::FC_READ_INPUT, 16'h0010, 9, 0, 0);
        add(0, 5, mbrs_pkg::FC_READ_INPUT, 16'h0012, 0, 0, 0);
        add(1, 5, 0, 16'h0011, 0, 16'h0BAD, 0);
        add(0, 5, mbrs_pkg::FC_WRITE_ONE, 16'h0100, 16'hABCD, 0, 0);
        add(0, 0, mbrs_pkg::FC_WRITE_ONE, 16'h0109, 16'h0001, 0, 0);
        add(0, 5, mbrs_pkg::FC_WRITE_ONE, 16'h010A, 16'h5555, 0, 0);
        add(0, 5, mbrs_pkg::FC_WRITE_MANY, 16'h0102, 3, 16'h1111, 0);
        add(0, 5, mbrs_pkg::FC_WRITE_MANY, 16'h0102, 3, 16'h2222, 0);
        add(0, 5, mbrs_pkg::FC_WRITE_MANY, 16'h0102, 3, 16'h3333, 0);
        add(0, 5, mbrs_pkg::FC_WRITE_MANY, 16'h0102, 3, 16'h4444, 1);
        add(0, 0, mbrs_pkg::FC_WRITE_MANY, 16'h0106, 2, 16'h00FF, 0);
        add(0, 0, mbrs_pkg::FC_WRITE_MANY, 16'h0106, 2, 16'hFF00, 1);
        add(0, 5, mbrs_pkg::FC_WRITE_MANY, 16'h0100, 2, 16'h7777, 0);
        add(0, 5, mbrs_pkg::FC_READ_HOLD, 16'h0100, 10, 0, 0);
        add(0, 0, mbrs_pkg::FC_READ_HOLD, 16'h0100, 2, 0, 0);
        add(0, 6, mbrs_pkg::FC_READ_HOLD, 16'h0100, 2, 0, 0);
        add(0, 5, FC_UNKNOWN, 16'h0100, 2, 0, 0);
        add(0, 5, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
        drain();

        // full windows at the top of the address range and at zero
        set_windows(247, 16'hFFC0, 64, 16'h0000, 64);
        add(0, 247, mbrs_pkg::FC_READ_HOLD, 16'h0000, 29, 0, 0);
        add(0, 247, mbrs_pkg::FC_READ_HOLD, 16'h0000, 30, 0, 0);
        add(0, 247, mbrs_pkg::FC_READ_INPUT, 16'hFFE3, 29, 0, 0);
        random_requests(25);
        drain();

        // long receiver hold-off while reads pile up
        rcv_hold = 400;
        for (int i = 0; i < 8; i++)
            add(0, 247, mbrs_pkg::FC_READ_HOLD, 16'(i * 4), 6, 0, 0);
        drain();

        // oversized and one-entry windows, idling swapped
        snd_idle = 56;
        rcv_idle = 19;
        set_windows(1, 16'hFFFF, 1, 16'h8000, 127);
        random_requests(20);
        drain();

        // disabled input window, no idling
        snd_idle = 0;
        rcv_idle = 0;
        set_windows(42, 16'h0064, 0, 16'h03E8, 33);
        random_requests(12);
        drain();
        cfg_write(mbrs_pkg::CFG_IN_COUNT, 40);
        random_requests(12);
        drain();

        $display("Accepted %0d items, checked %0d results (%0d update notices)",
                 n_acc, n_rsp, n_notice);
        $display("Windows ran through reset, small, full, oversized and disabled settings");
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/mbrs_pkg.sv
hdl/mbrs_ram.sv
hdl/mbrs_front.sv
hdl/mbrs_back.sv
hdl/modbus_rtu_slave_register_handler.sv
dv/tb_modbus_rtu_slave_register_handler.sv
